// File: rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the seconds-to-calendar unit
// Holds the controller state and divider operation codes, the command and
// status bundles between controller and datapath, and calendar helpers.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int DIV_W   = 32;
  localparam int QUO_W   = 16;
  localparam int REM_W   = 17;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;

  localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [REM_W-1:0] DAYS_PER_WEEK = 17'd7;

  // Scaled reciprocals, rounded up. Each divisor has its power-of-two factor
  // shifted off the dividend first: 86400 = 675 << 7, 3600 = 225 << 4,
  // 60 = 15 << 2. The quotient is then the product shifted right by 35, 21,
  // 14 and 19 bits, exact over the whole operand range of each division.
  localparam logic [MUL_B_W-1:0] RECIP_DAY  = 26'd50903317;
  localparam logic [MUL_B_W-1:0] RECIP_HOUR = 26'd9321;
  localparam logic [MUL_B_W-1:0] RECIP_MIN  = 26'd1093;
  localparam logic [MUL_B_W-1:0] RECIP_WDAY = 26'd74899;

  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
  localparam logic [15:0] EPOCH_WEEKDAY    = 16'd4;
  localparam logic [3:0]  MONTH_JAN        = 4'd1;
  localparam logic [3:0]  MONTH_FEB        = 4'd2;
  localparam logic [3:0]  MONTH_APR        = 4'd4;
  localparam logic [3:0]  MONTH_JUN        = 4'd6;
  localparam logic [3:0]  MONTH_SEP        = 4'd9;
  localparam logic [3:0]  MONTH_NOV        = 4'd11;
  localparam logic [3:0]  MONTHS_PER_YEAR  = 4'd12;
  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAYS,
    S_YEAR,
    S_MONTH,
    S_JOIN
  } stc_state_t;

  typedef enum logic [1:0] {
    OP_DAYS,
    OP_HOUR,
    OP_MIN,
    OP_WDAY
  } stc_div_op_t;

  typedef struct packed {
    logic        div_start;
    stc_div_op_t start_op;
    logic        div_capture;
    stc_div_op_t cur_op;
    logic        cal_init;
    logic        year_step;
    logic        month_step;
    logic        out_load;
  } stc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_fit;
    logic month_fit;
  } stc_status_t;

  // Years handled here run from 1970 to 2106, so the only century year that
  // breaks the every-fourth-year rule is 2100.
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != NON_LEAP_CENTURY);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/seconds_to_calendar_unit.sv
// A conversion takes longer for later dates, once the year and month walk,
// one step per cycle, outlasts the divisions. The day split runs first; the
// hour, minute and weekday divisions overlap the walk on the same divider.
// Throughput: one item per conversion; the next item is taken while the last
// result still waits in the output register. Reset clears control and valids.
// ----------------------------------------------------------------------------
// seconds_to_calendar_unit: seconds since 1970 to Gregorian date and time
// Converts an unsigned 32-bit seconds count into year, month, day of month,
// hour, minute, second and weekday, with Sunday as weekday 0.
// ----------------------------------------------------------------------------
module seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  // The controller only issues commands; all arithmetic and every payload
  // register lives in the datapath. An accepted item first goes through a
  // division by the seconds in a day. The day count then seeds the
  // calendar walk, which removes whole years (Gregorian leap rule over
  // 1970..2106) and then whole months, while the divider continues with hours,
  // minutes and the weekday. The result item is loaded into the output register
  // once both tracks have finished and the register is free.
  stc_pkg::stc_cmd_t    cmd;
  stc_pkg::stc_status_t sts;

  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  stc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_seconds       (in_seconds),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

endmodule

// File: rtl/stc_divider.sv
// ----------------------------------------------------------------------------
// stc_divider: constant divider by reciprocal multiplication
// Divides by one of four fixed divisors: the operand is captured at start,
// the quotient comes from a multiply by the scaled reciprocal, and the
// remainder from a multiply-subtract; done pulses for one cycle with results.
// ----------------------------------------------------------------------------
module stc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  stc_pkg::stc_div_op_t      op,
  input  logic [stc_pkg::DIV_W-1:0] dividend,
  output logic                      done,
  output logic [stc_pkg::QUO_W-1:0] quot,
  output logic [stc_pkg::REM_W-1:0] rem
);

  logic                      stg1_r;
  logic                      stg2_r;
  logic                      done_r;
  stc_pkg::stc_div_op_t      op_r;
  logic [stc_pkg::DIV_W-1:0] x_r;
  logic [stc_pkg::QUO_W-1:0] q_r;
  logic [stc_pkg::REM_W-1:0] r_r;

  logic [stc_pkg::MUL_A_W-1:0]                  mul_a;
  logic [stc_pkg::MUL_B_W-1:0]                  mul_b;
  logic [stc_pkg::MUL_A_W+stc_pkg::MUL_B_W-1:0] prod;
  logic [stc_pkg::QUO_W-1:0]                    q_nxt;
  logic [stc_pkg::REM_W-1:0]                    dvs;
  logic [stc_pkg::REM_W-1:0]                    qd;
  logic [stc_pkg::REM_W-1:0]                    r_nxt;

  always_comb begin
    unique case (op_r)
      stc_pkg::OP_DAYS: begin
        mul_a = x_r[31:7];
        mul_b = stc_pkg::RECIP_DAY;
        dvs   = stc_pkg::SECS_PER_DAY;
      end
      stc_pkg::OP_HOUR: begin
        mul_a = {12'd0, x_r[16:4]};
        mul_b = stc_pkg::RECIP_HOUR;
        dvs   = stc_pkg::SECS_PER_HOUR;
      end
      stc_pkg::OP_MIN: begin
        mul_a = {15'd0, x_r[11:2]};
        mul_b = stc_pkg::RECIP_MIN;
        dvs   = stc_pkg::SECS_PER_MIN;
      end
      stc_pkg::OP_WDAY: begin
        mul_a = {9'd0, x_r[15:0]};
        mul_b = stc_pkg::RECIP_WDAY;
        dvs   = stc_pkg::DAYS_PER_WEEK;
      end
      default: begin
        mul_a = x_r[31:7];
        mul_b = stc_pkg::RECIP_DAY;
        dvs   = stc_pkg::SECS_PER_DAY;
      end
    endcase

    prod = {26'd0, mul_a} * {25'd0, mul_b};

    unique case (op_r)
      stc_pkg::OP_DAYS: q_nxt = prod[50:35];
      stc_pkg::OP_HOUR: q_nxt = {11'd0, prod[25:21]};
      stc_pkg::OP_MIN:  q_nxt = {10'd0, prod[19:14]};
      stc_pkg::OP_WDAY: q_nxt = {3'd0, prod[31:19]};
      default:          q_nxt = prod[50:35];
    endcase

    // The true remainder is below its divisor, which fits in 17 bits, so
    // modulo-2^17 arithmetic on the low bits gives it exactly.
    qd    = {1'b0, q_r} * dvs;
    r_nxt = x_r[stc_pkg::REM_W-1:0] - qd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      stg2_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg1_r <= start;
      stg2_r <= stg1_r;
      done_r <= stg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= dividend;
      op_r <= op;
    end
    if (stg1_r) begin
      q_r <= q_nxt;
    end
    if (stg2_r) begin
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// File: rtl/stc_datapath.sv
// ----------------------------------------------------------------------------
// stc_datapath: divider, calendar walker and result registers
// Splits seconds into days and time of day with a shared divider, walks
// years and months off the day count, and holds the result item.
// ----------------------------------------------------------------------------
module stc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stc_pkg::stc_cmd_t    cmd,
  output stc_pkg::stc_status_t sts,
  input  logic [31:0]          in_seconds,
  output logic [11:0]          out_year,
  output logic [3:0]           out_month,
  output logic [4:0]           out_day_of_month,
  output logic [4:0]           out_hour,
  output logic [5:0]           out_minute,
  output logic [5:0]           out_second,
  output logic [2:0]           out_weekday
);

  logic [stc_pkg::DIV_W-1:0] dvd;
  logic                      div_done;
  logic [stc_pkg::QUO_W-1:0] div_quot;
  logic [stc_pkg::REM_W-1:0] div_rem;

  logic [15:0] days_r;
  logic [15:0] rem_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [2:0]  weekday_r;

  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;
  logic [2:0]  out_weekday_r;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [15:0] wday_base;

  // Operand for the next division, zero-extended to the divider width.
  always_comb begin
    wday_base = days_r + stc_pkg::EPOCH_WEEKDAY;
    unique case (cmd.start_op)
      stc_pkg::OP_DAYS: dvd = in_seconds;
      stc_pkg::OP_HOUR: dvd = {15'd0, div_rem};
      stc_pkg::OP_MIN:  dvd = {20'd0, div_rem[11:0]};
      stc_pkg::OP_WDAY: dvd = {16'd0, wday_base};
      default:          dvd = in_seconds;
    endcase
  end

  stc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .op       (cmd.start_op),
    .dividend (dvd),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    leap = stc_pkg::is_leap(year_r);
    ylen = leap ? stc_pkg::DAYS_LEAP_YEAR : stc_pkg::DAYS_COMMON_YEAR;
    mlen = stc_pkg::month_len(month_r, leap);
    sts.div_done  = div_done;
    sts.year_fit  = (rem_r < {7'd0, ylen});
    sts.month_fit = (rem_r < {11'd0, mlen}) || (month_r >= stc_pkg::MONTHS_PER_YEAR);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      unique case (cmd.cur_op)
        stc_pkg::OP_DAYS: days_r    <= div_quot;
        stc_pkg::OP_HOUR: hour_r    <= div_quot[4:0];
        stc_pkg::OP_MIN: begin
          minute_r <= div_quot[5:0];
          second_r <= div_rem[5:0];
        end
        stc_pkg::OP_WDAY: weekday_r <= div_rem[2:0];
        default:          days_r    <= div_quot;
      endcase
    end

    if (cmd.cal_init) begin
      rem_r   <= div_quot;
      year_r  <= stc_pkg::EPOCH_YEAR;
      month_r <= stc_pkg::MONTH_JAN;
    end else if (cmd.year_step) begin
      rem_r  <= rem_r - {7'd0, ylen};
      year_r <= year_r + 12'd1;
    end else if (cmd.month_step) begin
      rem_r   <= rem_r - {11'd0, mlen};
      month_r <= month_r + 4'd1;
    end

    if (cmd.out_load) begin
      out_year_r    <= year_r;
      out_month_r   <= month_r;
      out_day_r     <= rem_r[4:0] + 5'd1;
      out_hour_r    <= hour_r;
      out_minute_r  <= minute_r;
      out_second_r  <= second_r;
      out_weekday_r <= weekday_r;
    end
  end

  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_day_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_second       = out_second_r;
  assign out_weekday      = out_weekday_r;

endmodule

// File: rtl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl: sequencing controller
// Runs the day split, the year and month walk and the chain of time-of-day
// and weekday divisions, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module stc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  stc_pkg::stc_status_t sts,
  output stc_pkg::stc_cmd_t    cmd
);

  stc_pkg::stc_state_t  state_r;
  stc_pkg::stc_state_t  state_nxt;
  stc_pkg::stc_div_op_t div_op_r;
  stc_pkg::stc_div_op_t div_op_nxt;
  logic                 div_fin_r;
  logic                 div_fin_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stc_pkg::S_IDLE:  if (in_valid) state_nxt = stc_pkg::S_DAYS;
      stc_pkg::S_DAYS:  if (sts.div_done) state_nxt = stc_pkg::S_YEAR;
      stc_pkg::S_YEAR:  if (sts.year_fit) state_nxt = stc_pkg::S_MONTH;
      stc_pkg::S_MONTH: if (sts.month_fit) state_nxt = stc_pkg::S_JOIN;
      stc_pkg::S_JOIN:  if (div_fin_r && out_free) state_nxt = stc_pkg::S_IDLE;
      default:          state_nxt = stc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.start_op = stc_pkg::OP_DAYS;
    cmd.cur_op   = div_op_r;
    in_stall     = (state_r != stc_pkg::S_IDLE);

    // Division chain: each finished operation but the weekday one starts the next one.
    if (sts.div_done) begin
      cmd.div_capture = 1'b1;
      unique case (div_op_r)
        stc_pkg::OP_DAYS: begin
          cmd.cal_init  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.start_op  = stc_pkg::OP_HOUR;
        end
        stc_pkg::OP_HOUR: begin
          cmd.div_start = 1'b1;
          cmd.start_op  = stc_pkg::OP_MIN;
        end
        stc_pkg::OP_MIN: begin
          cmd.div_start = 1'b1;
          cmd.start_op  = stc_pkg::OP_WDAY;
        end
        stc_pkg::OP_WDAY: cmd.div_start = 1'b0;
        default:          cmd.div_start = 1'b0;
      endcase
    end

    unique case (state_r)
      stc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.div_start = 1'b1;
          cmd.start_op  = stc_pkg::OP_DAYS;
        end
      end
      stc_pkg::S_DAYS:  cmd.year_step  = 1'b0;
      stc_pkg::S_YEAR:  cmd.year_step  = !sts.year_fit;
      stc_pkg::S_MONTH: cmd.month_step = !sts.month_fit;
      stc_pkg::S_JOIN:  cmd.out_load   = div_fin_r && out_free;
      default:          cmd.out_load   = 1'b0;
    endcase
  end

  always_comb begin
    div_op_nxt  = cmd.div_start ? cmd.start_op : div_op_r;
    div_fin_nxt = div_fin_r;
    if (cmd.out_load) begin
      div_fin_nxt = 1'b0;
    end else if (sts.div_done && (div_op_r == stc_pkg::OP_WDAY)) begin
      div_fin_nxt = 1'b1;
    end
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stc_pkg::S_IDLE;
      div_op_r    <= stc_pkg::OP_DAYS;
      div_fin_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_op_r    <= div_op_nxt;
      div_fin_r   <= div_fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker: port-level checks of the seconds-to-calendar unit
// Watches the top-level ports only and is attached by the bind below.
// ----------------------------------------------------------------------------
module stc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second,
  input logic [2:0]  out_weekday
);

  // An accepted item keeps the input side closed while it is converted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // A conversion never finishes in the cycle right after acceptance.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

  // Every shown result lies within the calendar ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= 12'd1970) && (out_year <= 12'd2106) &&
                  (out_month >= 4'd1) && (out_month <= 4'd12) &&
                  (out_day_of_month >= 5'd1) && (out_hour <= 5'd23) &&
                  (out_minute <= 6'd59) && (out_second <= 6'd59) &&
                  (out_weekday <= 3'd6))
    else $error("result field out of range");

  // A stalled result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year) &&
      $stable(out_month) && $stable(out_day_of_month) && $stable(out_hour) &&
      $stable(out_minute) && $stable(out_second) && $stable(out_weekday))
    else $error("stalled result changed");

endmodule

bind seconds_to_calendar_unit stc_checker u_stc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_second       (out_second),
  .out_weekday      (out_weekday)
);

// File: tb/tb_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar_unit: self-checking bench for the calendar converter
// Feeds seconds counts through the valid/stall input port, predicts the
// Gregorian date, time of day and weekday for each accepted item, and checks
// every result in order while both ports idle and stall at random, but for one quiet stretch.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned FIRST_YEAR = 1970;
  // 1970-01-01 fell on a Thursday; Sunday counts as weekday zero.
  localparam int unsigned FIRST_WDAY = 4;
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Corner timestamps: field extremes, day, year and leap-day edges, the
  // signed 32-bit rollover, 2100 (not a leap year) and the top of the range.
  localparam int N_CORNERS = 23;
  localparam logic [31:0] CORNER_SECS [N_CORNERS] = '{
    32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000,                // end of 1970, start of 1971
    32'd68169599, 32'd68169600, 32'd68256000,  // Feb 28, Feb 29, Mar 1 of 1972
    32'd951782400, 32'd978307199,              // 2000 leap day, last second of 2000
    32'd2147483647, 32'd2147483648,
    32'd4107542399, 32'd4107542400,            // Feb 28 and Mar 1 of 2100
    32'd4133980799, 32'd4291747200,            // end of 2100, start of 2106
    32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555
  };

  // The hang limit lies well above the slowest conversion; nothing moving on
  // either port for that long means the block has hung.
  localparam int HANG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 250;
  localparam int IDLE_PCT    = 20;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
  } calendar_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [31:0] in_seconds = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  logic [31:0] pending_secs_q [$];   // items waiting to be offered
  calendar_t   expected_date_q [$];  // predicted results, oldest first
  logic        in_took   = 1'b0;     // an item was accepted at the last rising edge
  bit          calm      = 1'b0;     // suppresses all idling and stalling
  int          n_queued  = 0;
  int          n_sent    = 0;
  int          n_results = 0;
  int          n_errors  = 0;
  int          hang_cnt  = 0;

  seconds_to_calendar_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_seconds      (in_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day_of_month(out_day_of_month),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_weekday     (out_weekday)
  );

  always #4 clk = ~clk;

  // Full Gregorian rule: every fourth year, except centuries not divisible
  // by 400. Within 1970..2106 only 2100 is affected.
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Predicts the converter's result for one seconds count. Whole years and
  // then whole months are peeled off the day count, mirroring the walk that
  // the block performs.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned left;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    calendar_t   c;
    days = secs / DAY_SECS;
    tod  = secs % DAY_SECS;
    left = days;
    yr   = FIRST_YEAR;
    forever begin
      span = leap_year(yr) ? 366 : 365;
      if (left < span) break;
      left -= span;
      yr++;
    end
    // December takes whatever remains once the first eleven months are gone.
    for (mon = 1; mon < 12; mon++) begin
      span = MONTH_LEN[mon-1] + ((mon == 2 && leap_year(yr)) ? 1 : 0);
      if (left < span) break;
      left -= span;
    end
    c.year   = yr[11:0];
    c.month  = mon[3:0];
    c.mday   = 5'(left + 1);
    c.hour   = 5'(tod / HOUR_SECS);
    c.minute = 6'((tod % HOUR_SECS) / MIN_SECS);
    c.second = 6'(tod % MIN_SECS);
    c.wday   = 3'((days + FIRST_WDAY) % 7);
    return c;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Random timestamps. Most are uniform over the whole 32-bit range, which
  // toggles every input bit; the rest crowd into the early years, the 2100
  // stretch at the top of the range, and the hours around New Year.
  task automatic queue_random(input int count);
    logic [31:0]  secs;
    int unsigned  yr;
    int unsigned  y;
    longint       start;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        6, 7: secs = $urandom_range(0, 32'd500000000);
        8:    secs = $urandom_range(32'd4102444800, 32'hFFFFFFFF);
        9: begin
          yr    = $urandom_range(FIRST_YEAR + 1, 2106);
          start = 0;
          for (y = FIRST_YEAR; y < yr; y++) start += (leap_year(y) ? 366 : 365) * DAY_SECS;
          secs = 32'(start + $urandom_range(0, 2 * DAY_SECS) - DAY_SECS);
        end
        default: secs = $urandom();
      endcase
      pending_secs_q.push_back(secs);
      n_queued++;
    end
  endtask

  task automatic wait_all_sent();
    while (n_sent != n_queued) @(posedge clk);
  endtask

  task automatic wait_all_results();
    while (n_results != n_sent) @(posedge clk);
  endtask

  // Driver. Inputs move only at the falling edge. A new item is offered once
  // the previous one was taken; a stalled item stays on the port untouched.
  // While no item is offered the payload carries noise.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_secs_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_seconds <= pending_secs_q.pop_front();
        in_valid   <= 1'b1;
      end else begin
        in_seconds <= $urandom();
        in_valid   <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor. At each rising edge an accepted input item gets its prediction
  // queued, and an accepted result is checked against the oldest prediction.
  // The hang counter restarts whenever anything moves on either port.
  always @(posedge clk) begin
    calendar_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_date_q.push_back(calendar_of(in_seconds));
      n_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_date_q.size() == 0) begin
        $error("result with no item outstanding: %0d-%0d-%0d", out_year, out_month,
               out_day_of_month);
        n_errors++;
      end else begin
        want = expected_date_q.pop_front();
        check_field("year",         want.year,   out_year);
        check_field("month",        want.month,  out_month);
        check_field("day_of_month", want.mday,   out_day_of_month);
        check_field("hour",         want.hour,   out_hour);
        check_field("minute",       want.minute, out_minute);
        check_field("second",       want.second, out_second);
        check_field("weekday",      want.wday,   out_weekday);
      end
    end
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall)) begin
      hang_cnt = 0;
    end else begin
      hang_cnt++;
      if (hang_cnt >= HANG_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", HANG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Test sequence: reset, the corner timestamps, then a pause until every
  // result is back, then three random stretches, the middle one with neither
  // side idling, and finally a drain.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_CORNERS; i++) begin
      pending_secs_q.push_back(CORNER_SECS[i]);
      n_queued++;
    end
    wait_all_sent();
    // Sender holds off here until the block has returned every result.
    wait_all_results();

    queue_random(220);
    wait_all_sent();
    calm = 1'b1;
    queue_random(200);
    wait_all_sent();
    calm = 1'b0;
    queue_random(230);
    wait_all_sent();
    wait_all_results();
    // Extra cycles catch any stray result after the last expected one.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d timestamps (%0d corner cases, the rest random over 1970..2106),",
             n_sent, N_CORNERS);
    $display("checking %0d results under random idling, stalls and one quiet stretch.",
             n_results);
    if (n_errors == 0 && expected_date_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/stc_pkg.sv
rtl/stc_divider.sv
rtl/stc_datapath.sv
rtl/stc_ctrl.sv
rtl/seconds_to_calendar_unit.sv
rtl/stc_checker.sv
tb/tb_seconds_to_calendar_unit.sv
